>>> rtl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared widths, result and action codes, and the opcode-to-action mapping.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned KindW   = 2;
  localparam int unsigned OpW     = 4;
  localparam int unsigned ActionW = 3;
  localparam int unsigned LenW    = 64;
  localparam int unsigned KeyW    = 32;

  localparam logic [KindW-1:0] KIND_PAYLOAD   = 2'd0;
  localparam logic [KindW-1:0] KIND_EMPTY_END = 2'd1;
  localparam logic [KindW-1:0] KIND_ERROR     = 2'd2;

  localparam logic [ActionW-1:0] ACT_NONE    = 3'd0;
  localparam logic [ActionW-1:0] ACT_ECHO    = 3'd1;
  localparam logic [ActionW-1:0] ACT_PONG    = 3'd2;
  localparam logic [ActionW-1:0] ACT_CLOSE   = 3'd3;
  localparam logic [ActionW-1:0] ACT_INVALID = 3'd4;

  localparam logic [OpW-1:0] OP_CONT   = 4'h0;
  localparam logic [OpW-1:0] OP_TEXT   = 4'h1;
  localparam logic [OpW-1:0] OP_BINARY = 4'h2;
  localparam logic [OpW-1:0] OP_RSV_LO = 4'h3;
  localparam logic [OpW-1:0] OP_RSV_HI = 4'h7;
  localparam logic [OpW-1:0] OP_CLOSE  = 4'h8;
  localparam logic [OpW-1:0] OP_PING   = 4'h9;
  localparam logic [OpW-1:0] OP_PONG   = 4'hA;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [2:0] EXT16_LAST = 3'd1;
  localparam logic [2:0] EXT64_LAST = 3'd7;
  localparam logic [2:0] MASK_LAST  = 3'd3;

  function automatic logic [ActionW-1:0] action_of(input logic [OpW-1:0] op);
    logic [ActionW-1:0] act;
    unique case (op)
      OP_TEXT, OP_BINARY: act = ACT_ECHO;
      OP_PING:            act = ACT_PONG;
      OP_CLOSE:           act = ACT_CLOSE;
      OP_PONG:            act = ACT_NONE;
      default:            act = ACT_INVALID;
    endcase
    return act;
  endfunction

endpackage

>>> rtl/wsd_if.sv
// ----------------------------------------------------------------------------
// WebSocket deframer channels
// Valid/ready channels for received stream bytes and for deframed results.
// ----------------------------------------------------------------------------
interface wsd_in_if;
  logic                     valid;
  logic                     ready;
  logic [wsd_pkg::ByteW-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface wsd_out_if;
  logic                        valid;
  logic                        ready;
  logic [wsd_pkg::KindW-1:0]   kind;
  logic [wsd_pkg::ByteW-1:0]   payload_byte;
  logic [wsd_pkg::OpW-1:0]     opcode;
  logic                        frame_end;
  logic                        message_end;
  logic [wsd_pkg::ActionW-1:0] action;

  modport source (output valid, output kind, output payload_byte, output opcode,
                  output frame_end, output message_end, output action, input ready);
  modport sink   (input valid, input kind, input payload_byte, input opcode,
                  input frame_end, input message_end, input action, output ready);
endinterface

>>> rtl/websocket_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer core
// Parses an upgraded WebSocket byte stream and emits unmasked payload words.
// ----------------------------------------------------------------------------
// The rx channel carries one stream byte per word. The tx channel carries one
// result word: a payload byte, an empty-frame marker, or a protocol error,
// with frame and message end flags and the action for a finished message.
// Header bytes give no result unless they complete an empty frame or carry a
// reserved data opcode (3 to 7).
// A byte is taken into an input register and is processed there against the
// parser state. Its result is loaded into the result register, from which the
// word is offered on tx. One byte is taken every cycle while tx does not
// stall; the single state update per byte is the only loop.
// Reset clears the parser to the first header byte and empties both
// registers. When tx stalls, the result register holds, the input register
// fills behind it, and rx.ready drops until tx takes the waiting word.
// After a reserved opcode (3 to 7) the block drops further bytes until reset.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_core (
  input  logic              clk,
  input  logic              rst,
  wsd_in_if.sink            rx,
  wsd_out_if.source         tx
);

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT16,
    PH_EXT64,
    PH_MASK,
    PH_PAYLOAD
  } phase_t;

  phase_t                       phase, phase_next;
  logic [wsd_pkg::OpW-1:0]      message_opcode, message_opcode_next;
  logic                         fin_flag, fin_flag_next;
  logic                         mask_flag, mask_flag_next;
  logic [wsd_pkg::LenW-1:0]     remaining_length, remaining_length_next;
  logic [2:0]                   field_byte_count, field_byte_count_next;
  logic [wsd_pkg::KeyW-1:0]     mask_key, mask_key_next;
  logic [1:0]                   payload_index, payload_index_next;
  logic                         stopped, stopped_next;

  logic                         in_valid;
  logic [wsd_pkg::ByteW-1:0]    in_byte;

  logic                         out_valid;
  logic [wsd_pkg::KindW-1:0]    out_kind;
  logic [wsd_pkg::ByteW-1:0]    out_byte;
  logic [wsd_pkg::OpW-1:0]      out_opcode;
  logic                         out_fend;
  logic                         out_mend;
  logic [wsd_pkg::ActionW-1:0]  out_action;

  logic                         res_valid;
  logic [wsd_pkg::KindW-1:0]    res_kind;
  logic [wsd_pkg::ByteW-1:0]    res_byte;
  logic [wsd_pkg::OpW-1:0]      res_opcode;
  logic                         res_fend;

  logic                         advance;
  logic                         take;
  logic [wsd_pkg::OpW-1:0]      hdr_op;
  logic [wsd_pkg::LenW-1:0]     ext_length;
  logic [wsd_pkg::LenW-1:0]     done_length;
  logic                         done_go;
  logic [wsd_pkg::ByteW-1:0]    key_byte;

  assign advance  = in_valid && (!out_valid || tx.ready);
  assign rx.ready = !in_valid || advance;
  assign take     = rx.valid && rx.ready;

  assign hdr_op     = in_byte[3:0];
  assign ext_length = {remaining_length[wsd_pkg::LenW-9:0], in_byte};

  always_comb begin
    unique case (payload_index)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    phase_next            = phase;
    message_opcode_next   = message_opcode;
    fin_flag_next         = fin_flag;
    mask_flag_next        = mask_flag;
    remaining_length_next = remaining_length;
    field_byte_count_next = field_byte_count;
    mask_key_next         = mask_key;
    payload_index_next    = payload_index;
    stopped_next          = stopped;
    res_valid             = 1'b0;
    res_kind              = wsd_pkg::KIND_PAYLOAD;
    res_byte              = '0;
    res_opcode            = message_opcode;
    res_fend              = 1'b0;
    done_go               = 1'b0;
    done_length           = remaining_length;

    if (!stopped) begin
      unique case (phase)
        PH_HDR0: begin
          if (hdr_op >= wsd_pkg::OP_RSV_LO && hdr_op <= wsd_pkg::OP_RSV_HI) begin
            stopped_next = 1'b1;
            res_valid    = 1'b1;
            res_kind     = wsd_pkg::KIND_ERROR;
            res_opcode   = hdr_op;
          end else begin
            fin_flag_next = in_byte[7];
            if (hdr_op != wsd_pkg::OP_CONT) begin
              message_opcode_next = hdr_op;
            end
            phase_next = PH_HDR1;
          end
        end
        PH_HDR1: begin
          mask_flag_next        = in_byte[7];
          field_byte_count_next = '0;
          remaining_length_next = '0;
          if (in_byte[6:0] == wsd_pkg::LEN_EXT16) begin
            phase_next = PH_EXT16;
          end else if (in_byte[6:0] == wsd_pkg::LEN_EXT64) begin
            phase_next = PH_EXT64;
          end else begin
            remaining_length_next = {57'd0, in_byte[6:0]};
            done_length           = {57'd0, in_byte[6:0]};
            if (in_byte[7]) begin
              phase_next = PH_MASK;
            end else begin
              done_go = 1'b1;
            end
          end
        end
        PH_EXT16, PH_EXT64: begin
          remaining_length_next = ext_length;
          done_length           = ext_length;
          if (field_byte_count >= ((phase == PH_EXT16) ? wsd_pkg::EXT16_LAST
                                                        : wsd_pkg::EXT64_LAST)) begin
            if (mask_flag) begin
              phase_next            = PH_MASK;
              field_byte_count_next = '0;
            end else begin
              done_go = 1'b1;
            end
          end else begin
            field_byte_count_next = field_byte_count + 3'd1;
          end
        end
        PH_MASK: begin
          mask_key_next = {mask_key[23:0], in_byte};
          if (field_byte_count >= wsd_pkg::MASK_LAST) begin
            done_go = 1'b1;
          end else begin
            field_byte_count_next = field_byte_count + 3'd1;
          end
        end
        PH_PAYLOAD: begin
          payload_index_next    = payload_index + 2'd1;
          remaining_length_next = remaining_length - 64'd1;
          res_valid             = 1'b1;
          res_kind              = wsd_pkg::KIND_PAYLOAD;
          res_byte              = mask_flag ? (in_byte ^ key_byte) : in_byte;
          res_fend              = (remaining_length == 64'd1);
          if (remaining_length == 64'd1) begin
            phase_next = PH_HDR0;
          end
        end
        default: begin
          phase_next = PH_HDR0;
        end
      endcase

      if (done_go) begin
        payload_index_next    = '0;
        field_byte_count_next = '0;
        if (done_length == '0) begin
          phase_next = PH_HDR0;
          res_valid  = 1'b1;
          res_kind   = wsd_pkg::KIND_EMPTY_END;
          res_fend   = 1'b1;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid         <= 1'b0;
      out_valid        <= 1'b0;
      phase            <= PH_HDR0;
      message_opcode   <= '0;
      fin_flag         <= 1'b0;
      mask_flag        <= 1'b0;
      remaining_length <= '0;
      field_byte_count <= '0;
      mask_key         <= '0;
      payload_index    <= '0;
      stopped          <= 1'b0;
    end else begin
      if (take) begin
        in_valid <= 1'b1;
        in_byte  <= rx.data_byte;
      end else if (advance) begin
        in_valid <= 1'b0;
      end

      if (advance) begin
        phase            <= phase_next;
        message_opcode   <= message_opcode_next;
        fin_flag         <= fin_flag_next;
        mask_flag        <= mask_flag_next;
        remaining_length <= remaining_length_next;
        field_byte_count <= field_byte_count_next;
        mask_key         <= mask_key_next;
        payload_index    <= payload_index_next;
        stopped          <= stopped_next;
        out_valid        <= res_valid;
        out_kind         <= res_kind;
        out_byte         <= res_byte;
        out_opcode       <= res_opcode;
        out_fend         <= res_fend;
        out_mend         <= res_fend && fin_flag;
        out_action       <= (res_fend && fin_flag) ? wsd_pkg::action_of(message_opcode)
                                                   : wsd_pkg::ACT_NONE;
      end else if (tx.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign tx.valid        = out_valid;
  assign tx.kind         = out_kind;
  assign tx.payload_byte = out_byte;
  assign tx.opcode       = out_opcode;
  assign tx.frame_end    = out_fend;
  assign tx.message_end  = out_mend;
  assign tx.action       = out_action;

endmodule

>>> rtl/wsd_checker.sv
// ----------------------------------------------------------------------------
// WebSocket deframer checker
// Port-level properties of the deframer core, bound into the deframer core.
// ----------------------------------------------------------------------------
module wsd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        tx_valid,
  input logic                        tx_ready,
  input logic [wsd_pkg::KindW-1:0]   tx_kind,
  input logic [wsd_pkg::ByteW-1:0]   tx_payload_byte,
  input logic                        tx_frame_end,
  input logic                        tx_message_end,
  input logic [wsd_pkg::ActionW-1:0] tx_action
);

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !tx_valid)
    else $error("result pending after reset");

  // Only payload words carry a nonzero byte.
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    tx_valid && tx_kind != wsd_pkg::KIND_PAYLOAD |-> tx_payload_byte == '0)
    else $error("nonzero byte on a marker word");

  // Message end and an action only come with a frame end.
  a_mend_fend: assert property (@(posedge clk) disable iff (rst)
    tx_valid && !tx_frame_end |-> !tx_message_end && tx_action == wsd_pkg::ACT_NONE)
    else $error("message end or action without frame end");

  // No result is offered directly after a protocol error is taken; the core stops the stream until reset.
  a_error_stops: assert property (@(posedge clk) disable iff (rst)
    tx_valid && tx_ready && tx_kind == wsd_pkg::KIND_ERROR |=> !tx_valid)
    else $error("result after protocol error");

endmodule

bind websocket_frame_deframer_core wsd_checker u_wsd_checker (
  .clk             (clk),
  .rst             (rst),
  .tx_valid        (tx.valid),
  .tx_ready        (tx.ready),
  .tx_kind         (tx.kind),
  .tx_payload_byte (tx.payload_byte),
  .tx_frame_end    (tx.frame_end),
  .tx_message_end  (tx.message_end),
  .tx_action       (tx.action)
);
